### rtl/positional_deque_engine_assert.svh
// assertion macros for the positional deque engine checker
// no dependencies; included by the checker file
`ifndef POSITIONAL_DEQUE_ENGINE_ASSERT_SVH
`define POSITIONAL_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional deque engine check failed");

// next-cycle implication, disabled while in reset
`define PDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional deque engine check failed");

`endif

### rtl/pde_pkg.sv
// shared constants, mode codes and the cell control struct
// no dependencies; used by the engine top level and by pde_cell
`default_nettype none
package pde_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 7;
    localparam int MODE_W    = 3;
    localparam int LW        = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;
    localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd7;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 2'd0;
    localparam cell_op_t CELL_INSERT = 2'd1;
    localparam cell_op_t CELL_REMOVE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] index;
        word_t            word;
    } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/positional_deque_engine.sv
// top level of the positional deque engine: request decode, cell row, result register
// depends on pde_pkg and pde_cell
`default_nettype none
// Positional deque engine. Holds up to 64 signed 32-bit words in order and
// executes one request per clock when not stalled: push or pop at either
// end, insert, remove or read at a 1-based position, and reverse. The words
// sit in a row of 64 cells; an insert or remove shifts every cell past the
// target by one place toward its neighbor at once, and a reverse only flips
// an orientation flag that remaps logical to physical positions, so one
// request can be accepted per clock unless a waiting result stalls it. The
// result appears on the master side in the cycle after the request is
// taken, from an output register; a new request is taken while a result
// waits only once that result is taken in the same cycle. No clearing pass
// is needed after reset: only positions below the count are ever read.
module positional_deque_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] read_value, [38:32] count, [39] zero
    output logic [0:0]       m_tuser    // [0] ok
);
    import pde_pkg::*;

    // request fields
    logic [MODE_W-1:0] mode;
    word_t             value;
    logic [POS_W-1:0]  position;
    logic              accept;

    assign mode     = s_tuser;
    assign value    = s_tdata[WORD_BITS-1:0];
    assign position = s_tdata[WORD_BITS +: POS_W];

    // deque state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rev_reg;
    logic             rev_next;

    // result register
    logic             out_valid_reg;
    word_t            out_word_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_ok_reg;

    // decode results
    cell_ctl_t        ctl;
    logic [LW-1:0]    n_ext;
    logic [LW-1:0]    pos_ext;
    logic [LW-1:0]    pos_front;
    logic [LW-1:0]    ins_lidx;
    logic [LW-1:0]    lidx;
    logic [LW-1:0]    phys;
    logic             full;
    logic             empty;
    logic             pos_ok;
    logic             do_ins;
    logic             do_rem;
    logic             do_rd;
    logic             res_ok;
    word_t            res_word;

    // cell row
    word_t            cell_word [DEPTH];
    word_t            cell_tap  [DEPTH];
    word_t            left_w    [DEPTH];
    word_t            right_w   [DEPTH];
    word_t            tap_or;

    // a new request goes in when the result register is empty or drains now
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign n_ext     = LW'(count_reg);
    assign pos_ext   = LW'(position);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= n_ext);
    // position zero means the front; at or past the count means append
    assign pos_front = (pos_ext == '0) ? LW'(1) : pos_ext;
    assign ins_lidx  = (pos_front >= n_ext) ? n_ext : (pos_front - LW'(1));

    always_comb
    begin
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        do_rd    = 1'b0;
        res_ok   = 1'b0;
        lidx     = '0;
        rev_next = rev_reg;
        case (mode)
            MODE_PUSH_FRONT:
            begin
                do_ins = !full;
                res_ok = !full;
                lidx   = '0;
            end
            MODE_PUSH_BACK:
            begin
                do_ins = !full;
                res_ok = !full;
                lidx   = n_ext;
            end
            MODE_POP_FRONT:
            begin
                do_rem = !empty;
                do_rd  = !empty;
                res_ok = !empty;
                lidx   = '0;
            end
            MODE_POP_BACK:
            begin
                do_rem = !empty;
                do_rd  = !empty;
                res_ok = !empty;
                lidx   = n_ext - LW'(1);
            end
            MODE_INSERT:
            begin
                do_ins = !full;
                res_ok = !full;
                lidx   = ins_lidx;
            end
            MODE_REMOVE:
            begin
                do_rem = pos_ok;
                res_ok = pos_ok;
                lidx   = pos_ext - LW'(1);
            end
            MODE_READ:
            begin
                do_rd  = pos_ok;
                res_ok = pos_ok;
                lidx   = pos_ext - LW'(1);
            end
            MODE_REVERSE:
            begin
                res_ok = !empty;
                if (!empty)
                begin
                    rev_next = !rev_reg;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // logical to physical position; an insert slot runs 0..n, an element 0..n-1
    always_comb
    begin
        if (!rev_reg)
        begin
            phys = lidx;
        end
        else if (do_ins)
        begin
            phys = n_ext - lidx;
        end
        else
        begin
            phys = n_ext - LW'(1) - lidx;
        end
    end

    always_comb
    begin
        ctl.index = phys[IDX_W-1:0];
        ctl.word  = value;
        if (accept && do_ins)
        begin
            ctl.op = CELL_INSERT;
        end
        else if (accept && do_rem)
        begin
            ctl.op = CELL_REMOVE;
        end
        else
        begin
            ctl.op = CELL_HOLD;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_w[g] = '0;
            end
            else
            begin : g_mid_l
                assign left_w[g] = cell_word[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w[g] = '0;
            end
            else
            begin : g_mid_r
                assign right_w[g] = cell_word[g+1];
            end

            pde_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .cell_index (IDX_W'(g)),
                .left_word  (left_w[g]),
                .right_word (right_w[g]),
                .word       (cell_word[g]),
                .tap        (cell_tap[g])
            );
        end
    endgenerate

    // or of all taps: only the addressed cell is nonzero
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    assign res_word = do_rd ? tap_or : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rev_reg       <= rev_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg  <= res_word;
            out_count_reg <= count_next;
            out_ok_reg    <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_word_reg};
    assign m_tuser  = out_ok_reg;

endmodule
`default_nettype wire

### rtl/pde_cell.sv
// one storage cell of the deque row: holds a word, shifts with its neighbors
// depends on pde_pkg
`default_nettype none
module pde_cell (
    input  wire logic                    clk,
    input  wire pde_pkg::cell_ctl_t      ctl,
    input  wire logic [pde_pkg::IDX_W-1:0] cell_index,
    input  wire pde_pkg::word_t          left_word,
    input  wire pde_pkg::word_t          right_word,
    output pde_pkg::word_t               word,
    output pde_pkg::word_t               tap
);
    import pde_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (cell_index > ctl.index)
                begin
                    word_next = left_word;
                end
                else if (cell_index == ctl.index)
                begin
                    word_next = ctl.word;
                end
            end
            CELL_REMOVE:
            begin
                if (cell_index >= ctl.index)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // only the addressed cell drives its word onto the read tree
    assign tap  = (cell_index == ctl.index) ? word_reg : '0;

endmodule
`default_nettype wire

### rtl/pde_checker.sv
// port-level checks for the positional deque engine, bound to the top level
// depends on positional_deque_engine_assert.svh and positional_deque_engine
`default_nettype none
`include "positional_deque_engine_assert.svh"
module pde_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

    // a stalled result holds
    `PDE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // every taken request yields a result in the next cycle
    `PDE_ASSERT_NEXT(a_req_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)
    // an empty result register never blocks requests
    `PDE_ASSERT_NOW(a_ready_free, clk, rst_n, !m_tvalid, s_tready)
    // a refused or empty request returns a zero word and a bounded count
    `PDE_ASSERT_NOW(a_fail_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0)
    `PDE_ASSERT_NOW(a_count_max, clk, rst_n, m_tvalid, m_tdata[38:32] <= 7'd64)

endmodule

bind positional_deque_engine pde_checker u_pde_checker (.*);
`default_nettype wire
